@@ rtl/pshit_pkg.sv @@
// shared types and constants for the polygon store hit test block
package pshit_pkg;
  localparam int NUM_POLYGONS = 8;
  localparam int MAX_VERTICES = 128;
  localparam int COORD_BITS = 13;
  localparam int POLY_BITS = 3;
  localparam int VERT_BITS = 7;
  localparam int CNT_BITS = VERT_BITS + 1;
  localparam int ADDR_BITS = POLY_BITS + VERT_BITS;
  localparam int EDGE_BITS = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * EDGE_BITS;
  localparam logic [7:0] RADIUS_RESET = 8'd10;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_MOVE   = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NOVX = 2'd2
  } status_t;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE, B_EXEC, B_NEXT, B_FIRST, B_EDGE, B_WRAP, B_FLUSH, B_DONE
  } bstate_t;

  // classified item handed from front to back
  typedef struct packed {
    cmd_t                          cmd;
    logic [POLY_BITS-1:0]          poly;
    logic [VERT_BITS-1:0]          vert;
    logic signed [COORD_BITS-1:0]  x;
    logic signed [COORD_BITS-1:0]  y;
  } item_t;

  typedef struct packed {
    status_t              status;
    logic                 inside_res;
    logic [POLY_BITS-1:0] inside_polygon;
    logic                 near_found;
    logic [POLY_BITS-1:0] near_polygon;
    logic [VERT_BITS-1:0] near_vertex;
  } result_t;
endpackage

@@ rtl/pshit_queue.sv @@
// two-entry queue between front and back
module pshit_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  pshit_pkg::item_t wr_item,
  output logic           rd_valid,
  input  logic           rd_ready,
  output pshit_pkg::item_t rd_item
);
  import pshit_pkg::*;
  item_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_item  = mem_r[rp_r];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_item;
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2) else $error("queue count out of range");
  a_empty_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !rd_valid) else $error("read from empty queue");
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !rd_en && cnt_r == 2'd1 |=> cnt_r == 2'd2) else $error("count lost");
`endif
endmodule

@@ rtl/pshit_back.sv @@
// back end: vertex store, counts and the query sequencer
module pshit_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pshit_pkg::item_t in_item,
  input  logic [7:0]       radius,
  output logic             res_valid,
  input  logic             res_ready,
  output pshit_pkg::result_t res
);
  import pshit_pkg::*;

  logic signed [COORD_BITS-1:0] xs_mem [NUM_POLYGONS*MAX_VERTICES];
  logic signed [COORD_BITS-1:0] ys_mem [NUM_POLYGONS*MAX_VERTICES];
  logic [CNT_BITS-1:0] count_r [NUM_POLYGONS];

  bstate_t state_r, state_nxt;
  item_t   cur_r;
  result_t res_r, res_nxt;   // result being built
  result_t out_r;            // result offered on the output
  logic out_valid_r, out_valid_nxt;
  logic [POLY_BITS-1:0] p_r, p_nxt;
  logic [CNT_BITS-1:0]  i_r, i_nxt;     // next vertex to fetch
  logic odd_r, odd_nxt;
  logic signed [COORD_BITS-1:0] fx_r, fy_r, fx_nxt, fy_nxt;   // first vertex
  logic signed [COORD_BITS-1:0] ax_r, ay_r, ax_nxt, ay_nxt;   // previous vertex
  logic signed [COORD_BITS-1:0] rdx_r, rdy_r;
  logic rd_en;
  logic [ADDR_BITS-1:0] rd_addr;
  logic wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [CNT_BITS-1:0]  n_cur, n_edit;
  logic last_poly, out_free, accept, load_out;
  logic cnt_inc, cnt_clr;

  // edge test pipeline stage: products registered
  logic e_v_r, e_cross_r, e_up_r;
  logic signed [PROD_BITS-1:0] m1_r, m2_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      xs_mem[wr_addr] <= cur_r.x;
      ys_mem[wr_addr] <= cur_r.y;
    end
    if (rd_en) begin
      rdx_r <= xs_mem[rd_addr];
      rdy_r <= ys_mem[rd_addr];
    end
  end

  assign n_cur = count_r[p_r];
  assign n_edit = count_r[cur_r.poly];
  assign rd_addr = {p_r, i_r[VERT_BITS-1:0]};
  assign last_poly = p_r == POLY_BITS'(NUM_POLYGONS - 1);
  assign out_free = !out_valid_r || res_ready;
  assign in_ready = state_r == B_IDLE;
  assign accept = in_valid && in_ready;

  // edge from a to b against query point; the wrap edge closes last -> first
  logic wrap_sel, fire;
  logic signed [COORD_BITS-1:0] bx, by;
  logic signed [EDGE_BITS-1:0] dbx, dpy, dpx, dby;
  logic signed [EDGE_BITS-1:0] ndx, ndy, rr;
  logic near_hit;
  always_comb begin
    wrap_sel = state_r == B_WRAP;
    fire = (state_r == B_EDGE) || wrap_sel;
    bx = wrap_sel ? fx_r : rdx_r;
    by = wrap_sel ? fy_r : rdy_r;
    dbx = EDGE_BITS'(bx) - EDGE_BITS'(ax_r);
    dby = EDGE_BITS'(by) - EDGE_BITS'(ay_r);
    dpx = EDGE_BITS'(cur_r.x) - EDGE_BITS'(ax_r);
    dpy = EDGE_BITS'(cur_r.y) - EDGE_BITS'(ay_r);
    ndx = EDGE_BITS'(rdx_r) - EDGE_BITS'(cur_r.x);
    ndy = EDGE_BITS'(rdy_r) - EDGE_BITS'(cur_r.y);
    rr  = EDGE_BITS'($signed({1'b0, radius}));
    near_hit = (ndx < rr) && (ndx > -rr) && (ndy < rr) && (ndy > -rr);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else begin
      e_v_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    e_cross_r <= (ay_r > cur_r.y) != (by > cur_r.y);
    e_up_r <= by > ay_r;
    m1_r <= PROD_BITS'(dbx) * PROD_BITS'(dpy);
    m2_r <= PROD_BITS'(dpx) * PROD_BITS'(dby);
  end

  logic signed [PROD_BITS-1:0] cr;
  logic flip;
  assign cr = m1_r - m2_r;
  assign flip = e_v_r && e_cross_r && (e_up_r ? (cr > 0) : (cr < 0));

  always_comb begin
    state_nxt = state_r;
    res_nxt = res_r;
    p_nxt = p_r;
    i_nxt = i_r;
    odd_nxt = odd_r ^ flip;
    fx_nxt = fx_r; fy_nxt = fy_r; ax_nxt = ax_r; ay_nxt = ay_r;
    rd_en = 1'b0;
    wr_en = 1'b0;
    wr_addr = {cur_r.poly, cur_r.vert};
    cnt_inc = 1'b0;
    cnt_clr = 1'b0;
    load_out = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (accept) begin
          res_nxt = '0;
          p_nxt = '0;
          i_nxt = '0;
          odd_nxt = 1'b0;
          state_nxt = (in_item.cmd == CMD_QUERY) ? B_NEXT : B_EXEC;
        end
      end
      B_EXEC: begin
        case (cur_r.cmd)
          CMD_CLEAR: cnt_clr = 1'b1;
          CMD_APPEND: begin
            if (n_edit == CNT_BITS'(MAX_VERTICES)) res_nxt.status = ST_FULL;
            else begin
              wr_en = 1'b1;
              wr_addr = {cur_r.poly, n_edit[VERT_BITS-1:0]};
              cnt_inc = 1'b1;
            end
          end
          CMD_MOVE: begin
            if (CNT_BITS'(cur_r.vert) >= n_edit) res_nxt.status = ST_NOVX;
            else wr_en = 1'b1;
          end
          default: ;
        endcase
        state_nxt = B_DONE;
      end
      B_NEXT: begin
        // start a polygon: fetch vertex 0, or skip to the next one if it is empty
        if (n_cur == '0) begin
          if (last_poly) state_nxt = B_DONE;
          else p_nxt = p_r + 1'b1;
        end else begin
          rd_en = 1'b1;
          i_nxt = CNT_BITS'(1);
          state_nxt = B_FIRST;
        end
      end
      B_FIRST: begin
        fx_nxt = rdx_r; fy_nxt = rdy_r;
        ax_nxt = rdx_r; ay_nxt = rdy_r;
        if (near_hit && !res_r.near_found) begin
          res_nxt.near_found = 1'b1;
          res_nxt.near_polygon = p_r;
          res_nxt.near_vertex = '0;
        end
        if (n_cur > CNT_BITS'(1)) begin
          rd_en = 1'b1;
          i_nxt = i_r + 1'b1;
          state_nxt = B_EDGE;
        end else state_nxt = B_FLUSH;
      end
      B_EDGE: begin
        // fetched data is vertex i_r - 1, the end of the current edge
        ax_nxt = rdx_r; ay_nxt = rdy_r;
        if (near_hit && !res_r.near_found) begin
          res_nxt.near_found = 1'b1;
          res_nxt.near_polygon = p_r;
          res_nxt.near_vertex = VERT_BITS'(i_r - 1'b1);
        end
        if (i_r < n_cur) begin
          rd_en = 1'b1;
          i_nxt = i_r + 1'b1;
        end else state_nxt = B_WRAP;
      end
      B_WRAP: state_nxt = B_FLUSH;
      B_FLUSH: begin
        // flip of the wrap edge lands this cycle
        if ((odd_r ^ flip) && !res_r.inside_res) begin
          res_nxt.inside_res = 1'b1;
          res_nxt.inside_polygon = p_r;
        end
        odd_nxt = 1'b0;
        i_nxt = '0;
        if (last_poly) state_nxt = B_DONE;
        else begin
          p_nxt = p_r + 1'b1;
          state_nxt = B_NEXT;
        end
      end
      B_DONE: begin
        if (out_free) begin
          load_out = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
    out_valid_nxt = load_out ? 1'b1 : (out_valid_r && !res_ready);
  end

  assign res_valid = out_valid_r;
  assign res = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_POLYGONS; k++) count_r[k] <= '0;
      odd_r <= 1'b0;
      p_r <= '0;
      i_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      odd_r <= odd_nxt;
      p_r <= p_nxt;
      i_r <= i_nxt;
      if (cnt_clr) begin
        for (int k = 0; k < NUM_POLYGONS; k++) count_r[k] <= '0;
      end else if (cnt_inc) begin
        count_r[cur_r.poly] <= n_edit + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) cur_r <= in_item;
    if (load_out) out_r <= res_r;
    res_r <= res_nxt;
    fx_r <= fx_nxt; fy_r <= fy_nxt; ax_r <= ax_nxt; ay_r <= ay_nxt;
  end

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != B_IDLE |-> !in_ready) else $error("item taken while busy");
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[p_r] <= CNT_BITS'(MAX_VERTICES)) else $error("count overflow");
  a_done_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_DONE && out_free |=> res_valid) else $error("result not raised");
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result dropped");
`endif
endmodule

@@ rtl/polygon_store_hit_test.sv @@
// top level: cfg register, front classifier, queue, back end
// the back end holds one item at a time; a full output register holds it in its last state
// reset: synchronous active-low rst_n clears counts, control and near_radius to 10
module polygon_store_hit_test (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // command[1:0], polygon[4:2], vertex[11:5], x[24:12], y[37:25], zero fill to 40
  input  logic [39:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[1:0], inside_res[2], inside_polygon[5:3], near_found[6],
  // near_polygon[9:7], near_vertex[16:10], zero fill to 24
  output logic [23:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import pshit_pkg::*;

  logic [7:0] radius_r;
  item_t f_item;
  item_t q_item;
  logic q_valid, q_ready;
  result_t res;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {24'd0, radius_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) radius_r <= RADIUS_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      radius_r <= cfg_pwdata[7:0];
  end

  assign f_item.cmd  = cmd_t'(in_tdata[1:0]);
  assign f_item.poly = in_tdata[4:2];
  assign f_item.vert = in_tdata[11:5];
  assign f_item.x    = in_tdata[24:12];
  assign f_item.y    = in_tdata[37:25];

  pshit_queue u_q (
    .clk, .rst_n,
    .wr_valid(in_tvalid), .wr_ready(in_tready), .wr_item(f_item),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
  );

  pshit_back u_back (
    .clk, .rst_n,
    .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
    .radius(radius_r),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {7'd0, res.near_vertex, res.near_polygon, res.near_found,
                      res.inside_polygon, res.inside_res, res.status};
endmodule

@@ verif/tb_top.sv @@
// testbench for the polygon store hit test block: scoreboard class plus drivers
`timescale 1ns / 1ps

module tb_top;
  import pshit_pkg::*;

  class hit_scoreboard;
    logic signed [COORD_BITS-1:0] vx [NUM_POLYGONS*MAX_VERTICES];
    logic signed [COORD_BITS-1:0] vy [NUM_POLYGONS*MAX_VERTICES];
    int unsigned                  vcount [NUM_POLYGONS];
    int unsigned                  radius;
    result_t                      pending [$];
    int                           errors;

    function new();
      foreach (vcount[i]) vcount[i] = 0;
      radius = RADIUS_RESET;
      errors = 0;
    endfunction

    function bit polygon_holds(int p, longint px, longint py);
      bit odd;
      int n, j;
      longint ax, ay, bx, by, cr;
      odd = 0;
      n = vcount[p];
      for (int i = 0; i < n; i++) begin
        j = (i + 1 == n) ? 0 : i + 1;
        ax = vx[p*MAX_VERTICES+i];
        ay = vy[p*MAX_VERTICES+i];
        bx = vx[p*MAX_VERTICES+j];
        by = vy[p*MAX_VERTICES+j];
        if ((ay > py) != (by > py)) begin
          cr = (bx - ax) * (py - ay) - (px - ax) * (by - ay);
          if (by > ay ? (cr > 0) : (cr < 0)) odd = !odd;
        end
      end
      return odd;
    endfunction

    function void note_item(item_t it);
      result_t r;
      longint dx, dy, rr;
      int a;
      r = '0;
      r.status = ST_OK;
      case (it.cmd)
        CMD_CLEAR: foreach (vcount[i]) vcount[i] = 0;
        CMD_APPEND: begin
          if (vcount[it.poly] >= MAX_VERTICES) begin
            r.status = ST_FULL;
          end else begin
            a = it.poly * MAX_VERTICES + vcount[it.poly];
            vx[a] = it.x;
            vy[a] = it.y;
            vcount[it.poly]++;
          end
        end
        CMD_MOVE: begin
          if (it.vert >= vcount[it.poly]) begin
            r.status = ST_NOVX;
          end else begin
            a = it.poly * MAX_VERTICES + it.vert;
            vx[a] = it.x;
            vy[a] = it.y;
          end
        end
        default: begin
          rr = radius;
          for (int p = 0; p < NUM_POLYGONS && !r.inside_res; p++)
            if (polygon_holds(p, it.x, it.y)) begin
              r.inside_res = 1;
              r.inside_polygon = POLY_BITS'(p);
            end
          for (int p = 0; p < NUM_POLYGONS && !r.near_found; p++)
            for (int i = 0; i < vcount[p] && !r.near_found; i++) begin
              dx = longint'(vx[p*MAX_VERTICES+i]) - it.x;
              dy = longint'(vy[p*MAX_VERTICES+i]) - it.y;
              if (dx < rr && dx > -rr && dy < rr && dy > -rr) begin
                r.near_found = 1;
                r.near_polygon = POLY_BITS'(p);
                r.near_vertex = VERT_BITS'(i);
              end
            end
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status) begin
        $error("status exp %0d got %0d", e.status, got.status); errors++;
      end
      if (got.inside_res !== e.inside_res) begin
        $error("inside_res exp %0d got %0d", e.inside_res, got.inside_res); errors++;
      end
      if (got.inside_polygon !== e.inside_polygon) begin
        $error("inside_polygon exp %0d got %0d", e.inside_polygon, got.inside_polygon);
        errors++;
      end
      if (got.near_found !== e.near_found) begin
        $error("near_found exp %0d got %0d", e.near_found, got.near_found); errors++;
      end
      if (got.near_polygon !== e.near_polygon) begin
        $error("near_polygon exp %0d got %0d", e.near_polygon, got.near_polygon); errors++;
      end
      if (got.near_vertex !== e.near_vertex) begin
        $error("near_vertex exp %0d got %0d", e.near_vertex, got.near_vertex); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;  // command, polygon, vertex, x, y, zero fill
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;      // status, inside_res, inside_polygon, near_found,
                               // near_polygon, near_vertex, zero fill
  logic        cfg_psel = 0;
  logic        cfg_penable = 0;
  logic        cfg_pwrite = 0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  localparam logic [1:0] ADDR_NEAR_RADIUS = 2'd0;

  polygon_store_hit_test uut (.*);

  always #2 clk = ~clk;

  hit_scoreboard sb = new();
  int  send_idle = 0;     // percent of cycles the sender holds back
  int  recv_stall = 0;    // percent of cycles the receiver stalls
  bit  hold_off = 0;
  longint cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > 64'd4_000_000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic result_t unpack_result(logic [23:0] d);
    result_t r;
    r.status = status_t'(d[1:0]);
    r.inside_res = d[2];
    r.inside_polygon = d[5:3];
    r.near_found = d[6];
    r.near_polygon = d[9:7];
    r.near_vertex = d[16:10];
    return r;
  endfunction

  // receiver: ready changes on falling edge, results sampled at rising edge
  always @(negedge clk)
    out_tready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall);

  always @(posedge clk)
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(unpack_result(out_tdata));

  // returns at the accepting edge with valid still high
  task automatic send_item(cmd_t c, int p, int v, int x, int y);
    item_t it;
    it.cmd = c;
    it.poly = POLY_BITS'(p);
    it.vert = VERT_BITS'(v);
    it.x = COORD_BITS'(x);
    it.y = COORD_BITS'(y);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {2'b0, it.y, it.x, it.vert, it.poly, it.cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_radius(int r);
    cfg_psel <= 1;
    cfg_pwrite <= 1;
    cfg_paddr <= ADDR_NEAR_RADIUS;
    cfg_pwdata <= r;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    sb.radius = r & 8'hff;
  endtask

  function automatic int rcoord();
    case ($urandom_range(9))
      0: return -4096;
      1: return 4095;
      2, 3: return $urandom_range(8191) - 4096;
      default: return $urandom_range(400) - 200;
    endcase
  endfunction

  // a random polygon around a centre, then queries near it
  task automatic polygon_burst();
    int p, n, cx, cy, sz;
    p = $urandom_range(NUM_POLYGONS - 1);
    n = $urandom_range(1, 7);
    cx = $urandom_range(600) - 300;
    cy = $urandom_range(600) - 300;
    sz = $urandom_range(5, 150);
    for (int i = 0; i < n; i++)
      send_item(CMD_APPEND, p, 0, cx + $urandom_range(2*sz) - sz,
                cy + $urandom_range(2*sz) - sz);
    for (int i = 0; i < 4; i++)
      send_item(CMD_QUERY, 0, 0, cx + $urandom_range(2*sz) - sz,
                cy + $urandom_range(2*sz) - sz);
  endtask

  task automatic random_item();
    case ($urandom_range(19))
      0: send_item(CMD_CLEAR, $urandom_range(7), $urandom_range(127), rcoord(), rcoord());
      1, 2, 3: send_item(CMD_MOVE, $urandom_range(7),
                         $urandom_range(1) ? $urandom_range(127) : $urandom_range(8),
                         rcoord(), rcoord());
      4, 5, 6, 7: send_item(CMD_APPEND, $urandom_range(7), $urandom_range(127),
                            rcoord(), rcoord());
      default: send_item(CMD_QUERY, $urandom_range(7), $urandom_range(127),
                         rcoord(), rcoord());
    endcase
  endtask

  task automatic run_phase(int idle, int stall, int items);
    int done;
    send_idle = idle;
    recv_stall = stall;
    done = 0;
    while (done < items) begin
      if ($urandom_range(2) == 0) begin
        polygon_burst();
        done += 8;
      end else begin
        random_item();
        done++;
      end
      // keep the store small so queries stay short
      if ($urandom_range(29) == 0) begin
        send_item(CMD_CLEAR, 0, 0, 0, 0);
        done++;
      end
    end
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: square, edges, extremes, all commands, error cases
    send_item(CMD_QUERY, 0, 0, 0, 0);
    send_item(CMD_MOVE, 0, 0, 1, 1);
    send_item(CMD_APPEND, 0, 0, -100, -100);
    send_item(CMD_APPEND, 0, 0, 100, -100);
    send_item(CMD_APPEND, 0, 0, 100, 100);
    send_item(CMD_APPEND, 0, 0, -100, 100);
    send_item(CMD_QUERY, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, -100, 0);
    send_item(CMD_QUERY, 0, 0, 100, 0);
    send_item(CMD_QUERY, 0, 0, 91, 91);
    send_item(CMD_QUERY, 0, 0, 90, 90);
    send_item(CMD_APPEND, 7, 0, 4095, 4095);
    send_item(CMD_APPEND, 7, 0, -4096, -4096);
    send_item(CMD_QUERY, 7, 127, 4095, 4095);
    send_item(CMD_MOVE, 7, 1, -4096, 4095);
    send_item(CMD_MOVE, 7, 2, 0, 0);
    send_item(CMD_MOVE, 0, 127, 0, 0);
    send_item(CMD_QUERY, 0, 0, -4096, -4096);
    send_item(CMD_CLEAR, 7, 127, -1, -1);
    send_item(CMD_QUERY, 0, 0, 0, 0);
    // fill one polygon to capacity then overflow
    for (int i = 0; i < MAX_VERTICES; i++)
      send_item(CMD_APPEND, 3, 0, i * 8 - 500, (i % 2) ? 300 : -300);
    send_item(CMD_APPEND, 3, 0, 0, 0);
    send_item(CMD_MOVE, 3, 127, 5, 5);
    send_item(CMD_QUERY, 0, 0, 4, 6);
    send_item(CMD_CLEAR, 0, 0, 0, 0);
    drain();
    write_radius(0);
    send_item(CMD_APPEND, 1, 0, 5, 5);
    send_item(CMD_QUERY, 0, 0, 5, 5);
    drain();
    write_radius(255);
    send_item(CMD_QUERY, 0, 0, 259, -249);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) send_item(CMD_APPEND, 2, 0, i, -i);
    join

    run_phase(0, 0, 100);
    drain();
    write_radius($urandom_range(1, 254));
    run_phase(88, 0, 100);
    drain();
    write_radius(10);
    run_phase(0, 88, 100);
    drain();
    write_radius(255);
    run_phase(19, 19, 110);
    drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
